// ===== sv/psosc_pkg.sv =====
`default_nettype none

package psosc_pkg;

  localparam int FREQ_W    = 32;
  localparam int EXT_W     = 32;
  localparam int PERIOD_W  = 32;
  localparam int DEG_W     = 5;
  localparam int CFG_IDX_W = 4;

  // |u| and its powers: unsigned, 30 fraction bits, value in [0,1]
  localparam int FRAC_W    = 30;

  // shared multiplier operands, signed
  localparam int MUL_W     = 33;

  // frequency * sample_period, signed Q16.48
  localparam int PROD_W    = 64;
  localparam int PROD_FRAC = 48;

  localparam logic [DEG_W-1:0]    DEG_MIN      = 5'd2;
  localparam logic [DEG_W-1:0]    DEG_MAX      = 5'd17;
  localparam logic [DEG_W-1:0]    DEG_RESET    = 5'd2;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd89478;

  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 4'd1;

  typedef struct packed {
    logic upd;
    logic use_ext;
    logic trig;
  } phase_ctl_t;

endpackage

`default_nettype wire

// ===== sv/power_sine_oscillator.sv =====
// Power-curve sine oscillator. One input beat is one sample tick: the 0.PHASE_BITS phase
// either advances by frequency_i * sample_period (capped above at half a cycle) or loads
// external_phase_i, and reset_trigger_i then zeroes it. Each half cycle is shaped as
// +-(1 - |u|^k) with u = 4p-1 or 4p-3, k = degree, and delivered as one Q1.(OUT_BITS-1)
// beat on wave_value_o. Each beat is computed with the single shared multiplier through
// the states INC, PHASE, MAG, POW and FIN (k clamped to 2..17): one pass for the phase
// increment, then k-1 passes for the power. The result sits in an output register, so a
// new beat is accepted while the previous result waits. Config writes are always taken
// and must only happen while the block is idle.
`default_nettype none

module power_sine_oscillator #(
  parameter int PHASE_BITS = 32,
  parameter int OUT_BITS   = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [psosc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [psosc_pkg::PERIOD_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [psosc_pkg::FREQ_W-1:0]  frequency_i,
  input  logic [psosc_pkg::EXT_W-1:0]          external_phase_i,
  input  logic                                 use_external_i,
  input  logic                                 reset_trigger_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [OUT_BITS-1:0]           wave_value_o
);
  import psosc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INC   = 3'd1;
  localparam logic [2:0] S_PHASE = 3'd2;
  localparam logic [2:0] S_MAG   = 3'd3;
  localparam logic [2:0] S_POW   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam int RoundShift = FRAC_W - (OUT_BITS - 1);
  localparam logic [FRAC_W:0]   UnitW     = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [FRAC_W:0]   RoundHalf = (FRAC_W+1)'(1) << (RoundShift - 1);
  localparam logic [OUT_BITS-1:0] MaxPos  = {1'b0, {(OUT_BITS-1){1'b1}}};

  logic [2:0]               state_q, state_d;
  logic [DEG_W-1:0]         degree_q;
  logic [PERIOD_W-1:0]      period_q;
  logic signed [FREQ_W-1:0] freq_q;
  logic [EXT_W-1:0]         ext_q;
  logic                     use_ext_q, trig_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [FRAC_W:0]          a_q, pw_q;
  logic                     first_q;
  logic [DEG_W-1:0]         cnt_q, k_deg;
  logic                     out_valid_q;
  logic [OUT_BITS-1:0]      wave_q, wave_d;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  phase_ctl_t                ph_ctl;
  logic [FRAC_W:0]           mag;
  logic                      first;
  logic [FRAC_W:0]           r_mag, r_rnd;
  logic [OUT_BITS-1:0]       v_mag;
  logic                      in_fire, out_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_load    = (state_q == S_FIN) & (~out_valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEG_RESET;
      period_q <= PERIOD_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DEGREE) begin
        degree_q <= cfg_data_i[DEG_W-1:0];
      end else if (cfg_index_i == CFG_PERIOD) begin
        period_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    priority if (degree_q < DEG_MIN) begin
      k_deg = DEG_MIN;
    end else if (degree_q > DEG_MAX) begin
      k_deg = DEG_MAX;
    end else begin
      k_deg = degree_q;
    end
  end

  always_comb begin
    if (state_q == S_INC) begin
      mul_a = MUL_W'(freq_q);
      mul_b = MUL_W'(period_q);
    end else begin
      mul_a = MUL_W'(pw_q);
      mul_b = MUL_W'(a_q);
    end
  end

  psosc_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  assign ph_ctl.upd     = (state_q == S_PHASE);
  assign ph_ctl.use_ext = use_ext_q;
  assign ph_ctl.trig    = trig_q;

  psosc_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ph_ctl),
    .prod_i  (prod_q),
    .ext_i   (ext_q),
    .mag_o   (mag),
    .first_o (first)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_INC;
      S_INC:   state_d = S_PHASE;
      S_PHASE: state_d = S_MAG;
      S_MAG:   state_d = S_POW;
      S_POW:   if (cnt_q == DEG_W'(1)) state_d = S_FIN;
      S_FIN:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      freq_q    <= frequency_i;
      ext_q     <= external_phase_i;
      use_ext_q <= use_external_i;
      trig_q    <= reset_trigger_i;
    end
    if (state_q == S_INC) begin
      prod_q <= mul_p[PROD_W-1:0];
    end
    if (state_q == S_MAG) begin
      a_q     <= mag;
      pw_q    <= mag;
      first_q <= first;
      cnt_q   <= k_deg - DEG_W'(1);
    end
    if (state_q == S_POW) begin
      pw_q  <= mul_p[2*FRAC_W:FRAC_W];
      cnt_q <= cnt_q - DEG_W'(1);
    end
  end

  assign r_mag = UnitW - pw_q;
  assign r_rnd = r_mag + RoundHalf;
  assign v_mag = OUT_BITS'(r_rnd >> RoundShift);

  always_comb begin
    if (first_q) begin
      wave_d = (v_mag > MaxPos) ? MaxPos : v_mag;
    end else begin
      wave_d = -v_mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      wave_q <= wave_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign wave_value_o = wave_q;

endmodule

`default_nettype wire

// ===== sv/psosc_mul.sv =====
`default_nettype none

module psosc_mul (
  input  logic signed [psosc_pkg::MUL_W-1:0]   a_i,
  input  logic signed [psosc_pkg::MUL_W-1:0]   b_i,
  output logic signed [2*psosc_pkg::MUL_W-1:0] p_o
);
  import psosc_pkg::*;

  assign p_o = a_i * b_i;

endmodule

`default_nettype wire

// ===== sv/psosc_phase.sv =====
`default_nettype none

module psosc_phase #(
  parameter int PHASE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  psosc_pkg::phase_ctl_t               ctl_i,
  input  logic signed [psosc_pkg::PROD_W-1:0] prod_i,
  input  logic [psosc_pkg::EXT_W-1:0]         ext_i,
  output logic [psosc_pkg::FRAC_W:0]          mag_o,
  output logic                                first_o
);
  import psosc_pkg::*;

  localparam int IncShift = PROD_FRAC - PHASE_BITS;
  localparam logic signed [PROD_W-1:0] HalfCycle =
    {{(PROD_W-PROD_FRAC){1'b0}}, 1'b1, {(PROD_FRAC-1){1'b0}}};
  localparam logic [PHASE_BITS+1:0] One   = (PHASE_BITS+2)'(1) << PHASE_BITS;
  localparam logic [PHASE_BITS+1:0] Three = One + (One << 1);

  logic [PHASE_BITS-1:0]   phase_q, phase_d;
  logic signed [PROD_W-1:0] prod_c, inc_full;
  logic [PHASE_BITS-1:0]   inc, ext_ph;
  logic [PHASE_BITS+1:0]   four, ref_pt, au;

  assign prod_c   = (prod_i > HalfCycle) ? HalfCycle : prod_i;
  assign inc_full = prod_c >>> IncShift;
  assign inc      = inc_full[PHASE_BITS-1:0];

  if (PHASE_BITS >= EXT_W) begin : g_ext_wide
    assign ext_ph = PHASE_BITS'(ext_i) << (PHASE_BITS - EXT_W);
  end else begin : g_ext_narrow
    assign ext_ph = PHASE_BITS'(ext_i >> (EXT_W - PHASE_BITS));
  end

  always_comb begin
    phase_d = phase_q;
    if (ctl_i.upd) begin
      priority if (ctl_i.trig) begin
        phase_d = '0;
      end else if (ctl_i.use_ext) begin
        phase_d = ext_ph;
      end else begin
        phase_d = phase_q + inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  assign first_o = ~phase_q[PHASE_BITS-1];
  assign four    = {phase_q, 2'b00};
  assign ref_pt  = first_o ? One : Three;
  assign au      = (four >= ref_pt) ? (four - ref_pt) : (ref_pt - four);

  if (PHASE_BITS >= FRAC_W) begin : g_mag_wide
    assign mag_o = (FRAC_W+1)'(au >> (PHASE_BITS - FRAC_W));
  end else begin : g_mag_narrow
    assign mag_o = (FRAC_W+1)'(au) << (FRAC_W - PHASE_BITS);
  end

endmodule

`default_nettype wire

// ===== sv/psosc_chk.sv =====
`default_nettype none

module psosc_chk #(
  parameter int OUT_BITS = 16
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [OUT_BITS-1:0] wave_value_o
);

  // busy while a beat is in work
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a beat while still working");

  // no result straight after acceptance
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after acceptance");

  // a new result comes with the engine going idle
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result delivered while engine still busy");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped before taken");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(wave_value_o))
    else $error("output beat changed while stalled");

endmodule

bind power_sine_oscillator psosc_chk #(.OUT_BITS(OUT_BITS)) u_psosc_chk (.*);

`default_nettype wire

// ===== tb/tb_power_sine_oscillator.sv =====
`timescale 1ns / 1ps

module tb_power_sine_oscillator;
  import psosc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd9;
  localparam logic signed [63:0] INC_CLAMP = 64'sh0000_8000_0000_0000;
  localparam logic [63:0] PH_ONE = 64'h1_0000_0000;
  localparam logic [63:0] PH_THREE = 64'h3_0000_0000;
  localparam logic [63:0] MAG_ONE = 64'h4000_0000;
  localparam logic [31:0] PERIOD_44K1 = 32'd97391;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [PERIOD_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [FREQ_W-1:0] frequency_i = '0;
  logic [EXT_W-1:0] external_phase_i = '0;
  logic use_external_i = 1'b0;
  logic reset_trigger_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] wave_value_o;

  // oscillator state as the block should hold it
  logic [31:0] osc_phase = '0;
  logic [DEG_W-1:0] osc_degree = DEG_RESET;
  logic [PERIOD_W-1:0] osc_period = PERIOD_RESET;

  logic [15:0] wave_expect_q[$];
  logic [15:0] wave_exp;
  int fail_count = 0;
  bit src_idle_en = 1'b0;
  bit sink_idle_en = 1'b0;

  power_sine_oscillator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .frequency_i      (frequency_i),
    .external_phase_i (external_phase_i),
    .use_external_i   (use_external_i),
    .reset_trigger_i  (reset_trigger_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .wave_value_o     (wave_value_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Advance the phase for one sample tick and shape it into a Q1.15 sample.
  function automatic logic [15:0] shape_sample(logic [31:0] freq, logic [31:0] ext,
                                               logic use_ext, logic trig);
    logic signed [63:0] prod;
    logic [63:0] four;
    logic [63:0] mag;
    logic [63:0] pw;
    logic [63:0] r;
    logic [16:0] v;
    logic first;
    int k;
    int i;
    if (use_ext) begin
      osc_phase = ext;
    end else begin
      prod = $signed({{32{freq[31]}}, freq}) * $signed({32'd0, osc_period});
      if (prod > INC_CLAMP) prod = INC_CLAMP;
      osc_phase = osc_phase + prod[47:16];
    end
    if (trig) osc_phase = '0;
    first = !osc_phase[31];
    four = {30'd0, osc_phase, 2'b00};
    if (first) begin
      mag = (four >= PH_ONE) ? four - PH_ONE : PH_ONE - four;
    end else begin
      mag = (four >= PH_THREE) ? four - PH_THREE : PH_THREE - four;
    end
    mag = mag >> 2;
    k = (osc_degree < DEG_MIN) ? DEG_MIN : (osc_degree > DEG_MAX) ? DEG_MAX : osc_degree;
    pw = mag;
    for (i = 1; i < k; i++) pw = (pw * mag) >> FRAC_W;
    r = MAG_ONE - pw;
    v = 17'((r + 64'd16384) >> 15);
    if (first) begin
      if (v > 17'd32767) v = 17'd32767;
    end else begin
      v = -v;
    end
    return v[15:0];
  endfunction

  function automatic int pick_gap(bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] audio_freq();
    logic [31:0] f;
    f = $urandom_range(0, 32'd20000 << 16);
    return $urandom_range(0, 1) ? -f : f;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (wave_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected beat: wave_value_o=%0d", wave_value_o);
      end else begin
        wave_exp = wave_expect_q.pop_front();
        if (wave_value_o !== wave_exp) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("wave_value_o mismatch: expected %0d got %0d",
                     $signed(wave_exp), wave_value_o);
          end
        end
      end
    end
  end

  initial begin
    int n;
    @(posedge clk_i);
    forever begin
      n = pick_gap(sink_idle_en);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic send_tick(logic [31:0] freq, logic [31:0] ext, logic use_ext, logic trig);
    int gap;
    gap = pick_gap(src_idle_en);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    frequency_i <= freq;
    external_phase_i <= ext;
    use_external_i <= use_ext;
    reset_trigger_i <= trig;
    do @(posedge clk_i); while (!in_ready_o);
    wave_expect_q.push_back(shape_sample(freq, ext, use_ext, trig));
  endtask

  task automatic send_random_tick();
    int r;
    logic [31:0] f;
    logic [31:0] e;
    logic ue;
    logic tr;
    r = $urandom_range(0, 99);
    f = $urandom();
    e = $urandom();
    ue = 1'b0;
    tr = 1'b0;
    if (r < 62) begin
      f = audio_freq();
    end else if (r < 77) begin
      ue = 1'b1;
    end else if (r < 85) begin
      ue = $urandom_range(0, 1);
      tr = 1'b1;
    end
    send_tick(f, e, ue, tr);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (wave_expect_q.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_DEGREE) osc_degree = data[DEG_W-1:0];
    else if (idx == CFG_PERIOD) osc_period = data;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    send_tick('0, 32'h0000_0000, 1'b1, 1'b0);
    send_tick('0, 32'h0000_0001, 1'b1, 1'b0);
    send_tick('0, 32'h3FFF_FFFF, 1'b1, 1'b0);
    send_tick('0, 32'h4000_0000, 1'b1, 1'b0);
    send_tick('0, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_tick('0, 32'h8000_0000, 1'b1, 1'b0);
    send_tick('0, 32'hC000_0000, 1'b1, 1'b0);
    send_tick('0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_tick('0, 32'h1234_5678, 1'b1, 1'b1);
    repeat (3) send_tick(32'd440 << 16, '0, 1'b0, 1'b0);
    send_tick(32'h7FFF_FFFF, '0, 1'b0, 1'b0);
    send_tick(32'h8000_0000, '0, 1'b0, 1'b0);
    repeat (2) send_tick(-(32'd1000 << 16), '0, 1'b0, 1'b0);
    send_tick('0, '0, 1'b0, 1'b0);
    send_tick(32'd5000 << 16, '0, 1'b0, 1'b1);
    send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
  endtask

  task automatic test_degree_sweep();
    logic [DEG_W-1:0] degs[8] = '{5'd2, 5'd17, 5'd0, 5'd1, 5'd3, 5'd8, 5'd18, 5'd31};
    int d;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    for (d = 0; d < 8; d++) begin
      write_reg(CFG_DEGREE, {27'd0, degs[d]});
      send_tick('0, 32'h4000_0000, 1'b1, 1'b0);
      send_tick('0, 32'h8000_0000, 1'b1, 1'b0);
      send_tick('0, 32'h0000_0000, 1'b1, 1'b0);
      repeat (4) send_random_tick();
    end
  endtask

  task automatic test_period_extremes();
    logic [31:0] periods[4] = '{32'd0, 32'hFFFF_FFFF, 32'd1, PERIOD_44K1};
    int p;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b0;
    for (p = 0; p < 4; p++) begin
      write_reg(CFG_PERIOD, periods[p]);
      repeat (3) send_tick($urandom(), $urandom(), 1'b0, 1'b0);
      repeat (5) send_tick(audio_freq(), $urandom(), 1'b0, 1'b0);
    end
  endtask

  task automatic test_unmapped_index();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b1;
    write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
    repeat (8) send_random_tick();
  endtask

  task automatic test_random_run();
    int blk;
    for (blk = 0; blk < 5; blk++) begin
      src_idle_en = (blk != 1);
      sink_idle_en = (blk != 2);
      write_reg(CFG_DEGREE, $urandom_range(0, 31));
      case ($urandom_range(0, 2))
        0: write_reg(CFG_PERIOD, PERIOD_RESET);
        1: write_reg(CFG_PERIOD, $urandom_range(32'd10000, 32'd200000));
        default: write_reg(CFG_PERIOD, $urandom());
      endcase
      repeat (120) send_random_tick();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_degree_sweep();
    test_period_extremes();
    test_unmapped_index();
    test_random_run();
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/psosc_pkg.sv
sv/psosc_mul.sv
sv/psosc_phase.sv
sv/power_sine_oscillator.sv
sv/psosc_chk.sv
tb/tb_power_sine_oscillator.sv
